/* hw/rtl/data_stack_with_dup_swap_rot_macros.svh */
// ----------------------------------------------------------------------------
// data stack assertion macros
// shared concurrent assertion forms for the data stack
// ----------------------------------------------------------------------------
`ifndef DATA_STACK_WITH_DUP_SWAP_ROT_MACROS_SVH
`define DATA_STACK_WITH_DUP_SWAP_ROT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSTK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DSTK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dstk_pkg.sv */
// ----------------------------------------------------------------------------
// data stack package
// action and error codes, cell operations and default sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dstk_pkg;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int WORD_WIDTH_DEF  = 32;

	localparam int ACTION_W = 3;
	localparam int PORT_W   = 32;
	localparam int OFFSET_W = 8;
	localparam int DEPTH_W  = 9;
	localparam int ERROR_W  = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH = 3'd0,
		ACT_POP  = 3'd1,
		ACT_DUP  = 3'd2,
		ACT_SWAP = 3'd3,
		ACT_ROT  = 3'd4,
		ACT_PEEK = 3'd5
	} act_t;

	typedef enum logic [ERROR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_RANGE = 2'd2,
		ERR_OVER  = 2'd3
	} err_t;

	// hold, take from the cell above, take from the cell below, load
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_DOWN = 2'd1,
		CELL_UP   = 2'd2,
		CELL_LOAD = 2'd3
	} cell_op_t;

endpackage

/* hw/rtl/dstk_cell.sv */
// ----------------------------------------------------------------------------
// data stack cell
// one stack entry; shifts toward either neighbor or loads a new word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dstk_cell #(
	parameter int WORD_WIDTH = dstk_pkg::WORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  dstk_pkg::cell_op_t      op,
	input  logic [WORD_WIDTH-1:0]   above,
	input  logic [WORD_WIDTH-1:0]   below,
	input  logic [WORD_WIDTH-1:0]   ld,
	output logic [WORD_WIDTH-1:0]   val
);

	logic [WORD_WIDTH-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			dstk_pkg::CELL_HOLD: val_q <= val_q;
			dstk_pkg::CELL_DOWN: val_q <= above;
			dstk_pkg::CELL_UP:   val_q <= below;
			dstk_pkg::CELL_LOAD: val_q <= ld;
			default:             val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

/* hw/rtl/data_stack_with_dup_swap_rot.sv */
// ----------------------------------------------------------------------------
// data stack with dup, swap and rot
// bounded lifo stack built as a ring of shifting cells
// ----------------------------------------------------------------------------
// The stack is a ring of STACK_DEPTH cells with the top entry in the first
// cell whenever the stack is idle. Push, pop, dup, swap, rot and a peek at
// offset zero act on the item as it is taken: every cell shifts or loads in
// the same clock. A peek at offset k rotates the ring up k places, reads the
// first cell and rotates it back, one place per cycle each way. Each item
// gives one result, held in an output register until taken, and a new item
// is accepted once the previous one is finished and that register is free.
// The store is not cleared at reset; every other register is.
`timescale 1ns / 1ps

`include "data_stack_with_dup_swap_rot_macros.svh"

module data_stack_with_dup_swap_rot #(
	parameter int STACK_DEPTH = dstk_pkg::STACK_DEPTH_DEF,
	parameter int WORD_WIDTH  = dstk_pkg::WORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dstk_pkg::ACTION_W-1:0] action,
	input  logic [dstk_pkg::PORT_W-1:0]   push_value,
	input  logic [dstk_pkg::OFFSET_W-1:0] peek_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dstk_pkg::PORT_W-1:0]   read_value,
	output logic [dstk_pkg::DEPTH_W-1:0]  depth,
	output logic [dstk_pkg::ERROR_W-1:0]  error_code
);

	localparam int CW   = $clog2(STACK_DEPTH + 1);
	localparam int OW   = dstk_pkg::OFFSET_W;
	localparam int CMPW = (CW > OW) ? CW : OW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UP,
		S_READ,
		S_DOWN
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic [OW-1:0]          rot_q;
	logic [OW-1:0]          off_q;
	logic                   out_valid_q;
	logic [WORD_WIDTH-1:0]  rd_q;
	logic [CW-1:0]          depth_q;
	dstk_pkg::err_t         err_q;

	logic [WORD_WIDTH-1:0]  cell_val [STACK_DEPTH];
	logic [WORD_WIDTH-1:0]  cell_ld  [STACK_DEPTH];
	dstk_pkg::cell_op_t     cell_op  [STACK_DEPTH];

	logic                   in_fire;
	dstk_pkg::act_t         act;
	logic [WORD_WIDTH-1:0]  push_word;
	logic                   empty;
	logic                   full;
	logic                   off_bad;
	dstk_pkg::err_t         nx_err;
	logic [WORD_WIDTH-1:0]  nx_rd;
	logic [CW-1:0]          nx_cnt;
	logic                   go_peek;
	logic                   commit;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign act       = dstk_pkg::act_t'(action);
	assign push_word = WORD_WIDTH'(push_value);
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CW'(STACK_DEPTH));
	assign off_bad   = (CMPW'(peek_offset) >= CMPW'(cnt_q));

	// action decode for an item taken in idle
	always_comb begin
		nx_err  = dstk_pkg::ERR_OK;
		nx_rd   = '0;
		nx_cnt  = cnt_q;
		go_peek = 1'b0;
		unique case (act)
			dstk_pkg::ACT_PUSH: begin
				if (full) nx_err = dstk_pkg::ERR_OVER;
				else nx_cnt = cnt_q + CW'(1);
			end
			dstk_pkg::ACT_POP: begin
				if (empty) nx_err = dstk_pkg::ERR_UNDER;
				else begin
					nx_cnt = cnt_q - CW'(1);
					nx_rd  = cell_val[0];
				end
			end
			dstk_pkg::ACT_DUP: begin
				if (empty) nx_err = dstk_pkg::ERR_UNDER;
				else if (full) nx_err = dstk_pkg::ERR_OVER;
				else nx_cnt = cnt_q + CW'(1);
			end
			dstk_pkg::ACT_SWAP: begin
				if (cnt_q < CW'(2)) nx_err = dstk_pkg::ERR_UNDER;
			end
			dstk_pkg::ACT_ROT: begin
				if (cnt_q < CW'(3)) nx_err = dstk_pkg::ERR_UNDER;
			end
			dstk_pkg::ACT_PEEK: begin
				if (empty) nx_err = dstk_pkg::ERR_UNDER;
				else if (off_bad) nx_err = dstk_pkg::ERR_RANGE;
				else if (peek_offset == '0) nx_rd = cell_val[0];
				else go_peek = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign commit = in_fire && (nx_err == dstk_pkg::ERR_OK);

	// per-cell operation
	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			cell_op[i] = dstk_pkg::CELL_HOLD;
		end
		unique case (state_q)
			S_UP: begin
				for (int i = 0; i < STACK_DEPTH; i++) cell_op[i] = dstk_pkg::CELL_UP;
			end
			S_DOWN: begin
				for (int i = 0; i < STACK_DEPTH; i++) cell_op[i] = dstk_pkg::CELL_DOWN;
			end
			S_IDLE: begin
				if (commit) begin
					unique case (act)
						dstk_pkg::ACT_PUSH: begin
							for (int i = 1; i < STACK_DEPTH; i++) begin
								cell_op[i] = dstk_pkg::CELL_DOWN;
							end
							cell_op[0] = dstk_pkg::CELL_LOAD;
						end
						dstk_pkg::ACT_POP: begin
							for (int i = 0; i < STACK_DEPTH; i++) begin
								cell_op[i] = dstk_pkg::CELL_UP;
							end
						end
						dstk_pkg::ACT_DUP: begin
							for (int i = 1; i < STACK_DEPTH; i++) begin
								cell_op[i] = dstk_pkg::CELL_DOWN;
							end
						end
						dstk_pkg::ACT_SWAP: begin
							cell_op[0] = dstk_pkg::CELL_LOAD;
							cell_op[1] = dstk_pkg::CELL_LOAD;
						end
						dstk_pkg::ACT_ROT: begin
							cell_op[0] = dstk_pkg::CELL_LOAD;
							cell_op[1] = dstk_pkg::CELL_LOAD;
							cell_op[2] = dstk_pkg::CELL_LOAD;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// load words for the top three cells
	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			cell_ld[i] = '0;
		end
		if (act == dstk_pkg::ACT_ROT) cell_ld[0] = cell_val[2];
		else if (act == dstk_pkg::ACT_SWAP) cell_ld[0] = cell_val[1];
		else cell_ld[0] = push_word;
		cell_ld[1] = cell_val[0];
		cell_ld[2] = cell_val[1];
	end

	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		localparam int AB = (g + STACK_DEPTH - 1) % STACK_DEPTH;
		localparam int BE = (g + 1) % STACK_DEPTH;

		dstk_cell #(
			.WORD_WIDTH(WORD_WIDTH)
		) u_cell (
			.clk   (clk),
			.op    (cell_op[g]),
			.above (cell_val[AB]),
			.below (cell_val[BE]),
			.ld    (cell_ld[g]),
			.val   (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rot_q       <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
			rd_q        <= '0;
			depth_q     <= '0;
			err_q       <= dstk_pkg::ERR_OK;
		end else begin
			if (out_valid_q && out_ready && !(in_fire && !go_peek)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q <= nx_cnt;
						if (go_peek) begin
							off_q   <= peek_offset;
							rot_q   <= peek_offset;
							state_q <= S_UP;
						end else begin
							out_valid_q <= 1'b1;
							rd_q        <= nx_rd;
							depth_q     <= nx_cnt;
							err_q       <= nx_err;
						end
					end
				end
				S_UP: begin
					rot_q <= rot_q - OW'(1);
					if (rot_q == OW'(1)) state_q <= S_READ;
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					rd_q        <= cell_val[0];
					depth_q     <= cnt_q;
					err_q       <= dstk_pkg::ERR_OK;
					rot_q       <= off_q;
					state_q     <= S_DOWN;
				end
				S_DOWN: begin
					rot_q <= rot_q - OW'(1);
					if (rot_q == OW'(1)) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = dstk_pkg::PORT_W'(rd_q);
	assign depth      = dstk_pkg::DEPTH_W'(depth_q);
	assign error_code = err_q;

	`DSTK_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH), "entry count past depth")
	`DSTK_ASSERT_NOW(a_err_zero, out_valid_q && (err_q != dstk_pkg::ERR_OK), rd_q == '0, "error result with data")
	`DSTK_ASSERT_NEXT(a_push_cnt, in_fire && (act == dstk_pkg::ACT_PUSH) && !full, cnt_q == $past(cnt_q) + CW'(1), "push did not grow stack")
	`DSTK_ASSERT_NEXT(a_peek_cnt, state_q != S_IDLE, $stable(cnt_q), "count moved during peek")

endmodule

/* dv/tb_data_stack_with_dup_swap_rot.sv */
// ----------------------------------------------------------------------------
// data stack with dup, swap and rot testbench
// drives action items over valid/ready and checks every result against a
// behavioral stack kept in the bench; covers empty, shallow and full stacks,
// deep peeks, unused codes, random idling and a long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_data_stack_with_dup_swap_rot;

	localparam int DEPTH        = dstk_pkg::STACK_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 10000000;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct {
		logic [dstk_pkg::PORT_W-1:0]  rd;
		logic [dstk_pkg::DEPTH_W-1:0] dep;
		logic [dstk_pkg::ERROR_W-1:0] err;
	} stack_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [dstk_pkg::ACTION_W-1:0] action;
	logic [dstk_pkg::PORT_W-1:0]   push_value;
	logic [dstk_pkg::OFFSET_W-1:0] peek_offset;
	logic                          out_valid;
	logic                          out_ready;
	logic [dstk_pkg::PORT_W-1:0]   read_value;
	logic [dstk_pkg::DEPTH_W-1:0]  depth;
	logic [dstk_pkg::ERROR_W-1:0]  error_code;

	// bench copy of the stack
	logic [dstk_pkg::PORT_W-1:0] stk_mem [DEPTH];
	int unsigned                 stk_count;

	stack_result_t expected_results[$];
	int            fail_count;
	int            cycle_count;
	bit            send_idle;
	bit            recv_idle;
	int            hold_cycles;

	data_stack_with_dup_swap_rot #(
		.STACK_DEPTH(DEPTH),
		.WORD_WIDTH (dstk_pkg::WORD_WIDTH_DEF)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.push_value (push_value),
		.peek_offset(peek_offset),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.depth      (depth),
		.error_code (error_code)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic stack_result_t stack_apply(logic [dstk_pkg::ACTION_W-1:0] act,
			logic [dstk_pkg::PORT_W-1:0] val, logic [dstk_pkg::OFFSET_W-1:0] off);
		stack_result_t r;
		logic [dstk_pkg::PORT_W-1:0] a, b, c;
		r.rd  = '0;
		r.err = dstk_pkg::ERR_OK;
		case (act)
			dstk_pkg::ACT_PUSH: begin
				if (stk_count >= DEPTH) begin
					r.err = dstk_pkg::ERR_OVER;
				end else begin
					stk_mem[stk_count] = val;
					stk_count++;
				end
			end
			dstk_pkg::ACT_POP: begin
				if (stk_count == 0) begin
					r.err = dstk_pkg::ERR_UNDER;
				end else begin
					stk_count--;
					r.rd = stk_mem[stk_count];
				end
			end
			dstk_pkg::ACT_DUP: begin
				if (stk_count == 0) begin
					r.err = dstk_pkg::ERR_UNDER;
				end else if (stk_count >= DEPTH) begin
					r.err = dstk_pkg::ERR_OVER;
				end else begin
					stk_mem[stk_count] = stk_mem[stk_count-1];
					stk_count++;
				end
			end
			dstk_pkg::ACT_SWAP: begin
				if (stk_count < 2) begin
					r.err = dstk_pkg::ERR_UNDER;
				end else begin
					a = stk_mem[stk_count-1];
					stk_mem[stk_count-1] = stk_mem[stk_count-2];
					stk_mem[stk_count-2] = a;
				end
			end
			dstk_pkg::ACT_ROT: begin
				if (stk_count < 3) begin
					r.err = dstk_pkg::ERR_UNDER;
				end else begin
					a = stk_mem[stk_count-1];
					b = stk_mem[stk_count-2];
					c = stk_mem[stk_count-3];
					stk_mem[stk_count-1] = c;
					stk_mem[stk_count-2] = a;
					stk_mem[stk_count-3] = b;
				end
			end
			dstk_pkg::ACT_PEEK: begin
				if (stk_count == 0) begin
					r.err = dstk_pkg::ERR_UNDER;
				end else if (off >= stk_count) begin
					r.err = dstk_pkg::ERR_RANGE;
				end else begin
					r.rd = stk_mem[stk_count-1-off];
				end
			end
			default: begin
			end
		endcase
		r.dep = dstk_pkg::DEPTH_W'(stk_count);
		return r;
	endfunction

	task automatic send_item(input logic [dstk_pkg::ACTION_W-1:0] act,
			input logic [dstk_pkg::PORT_W-1:0] val,
			input logic [dstk_pkg::OFFSET_W-1:0] off);
		int gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		push_value  <= val;
		peek_offset <= off;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(stack_apply(act, val, off));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// result side
	initial begin
		int            stall;
		stack_result_t exp_r;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 9) : 0;
			if (hold_cycles > 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (read_value !== exp_r.rd) begin
					$error("read_value: expected %h, got %h", exp_r.rd, read_value);
					fail_count++;
				end
				if (depth !== exp_r.dep) begin
					$error("depth: expected %0d, got %0d", exp_r.dep, depth);
					fail_count++;
				end
				if (error_code !== exp_r.err) begin
					$error("error_code: expected %0d, got %0d", exp_r.err, error_code);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed();
		// empty stack errors and unused codes
		send_item(dstk_pkg::ACT_POP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_DUP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_SWAP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_ROT, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'hFF);
		send_item(3'd6, 32'hFFFF_FFFF, 8'hFF);
		send_item(3'd7, 32'h1234_5678, 8'h00);
		// shallow stack
		send_item(dstk_pkg::ACT_PUSH, 32'h0000_0000, 8'h00);
		send_item(dstk_pkg::ACT_SWAP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PUSH, 32'hFFFF_FFFF, 8'h00);
		send_item(dstk_pkg::ACT_ROT, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'h02);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'hFF);
		send_item(dstk_pkg::ACT_PUSH, 32'hA5A5_A5A5, 8'h00);
		send_item(dstk_pkg::ACT_ROT, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_SWAP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_DUP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'h03);
		send_item(3'd7, 32'h0, 8'h01);
		repeat (4) send_item(dstk_pkg::ACT_POP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_POP, 32'h0, 8'h00);
		wait_drained();
	endtask

	task automatic test_full_stack();
		while (stk_count < DEPTH) send_item(dstk_pkg::ACT_PUSH, $urandom, 8'(stk_count));
		send_item(dstk_pkg::ACT_PUSH, 32'hDEAD_BEEF, 8'h00);
		send_item(dstk_pkg::ACT_DUP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'hFF);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_ROT, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_SWAP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_POP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_DUP, 32'h0, 8'h00);
		send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'hFF);
		while (stk_count > 0) send_item(dstk_pkg::ACT_POP, 32'h0, 8'h00);
		wait_drained();
	endtask

	task automatic test_output_stall();
		send_idle   = 1'b0;
		hold_cycles = 300;
		repeat (10) send_item(dstk_pkg::ACT_PUSH, $urandom, 8'h00);
		repeat (4) send_item(dstk_pkg::ACT_ROT, 32'h0, 8'h00);
		repeat (6) send_item(dstk_pkg::ACT_PEEK, 32'h0, 8'($urandom_range(0, 9)));
		repeat (10) send_item(dstk_pkg::ACT_POP, 32'h0, 8'h00);
		wait_drained();
	endtask

	task automatic test_random();
		int                            sent;
		int                            target;
		int                            pick;
		int                            sel;
		int                            top_off;
		logic [dstk_pkg::ACTION_W-1:0] act;
		logic [dstk_pkg::PORT_W-1:0]   val;
		logic [dstk_pkg::OFFSET_W-1:0] off;
		sent   = 0;
		target = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 100 == 0) begin
				target    = $urandom_range(0, DEPTH);
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 2)
				act = dstk_pkg::ACTION_W'($urandom_range(6, 7));
			else if (pick < 40)
				act = (stk_count < target) ? dstk_pkg::ACT_PUSH : dstk_pkg::ACT_POP;
			else if (pick < 52)
				act = dstk_pkg::ACT_DUP;
			else if (pick < 64)
				act = dstk_pkg::ACT_SWAP;
			else if (pick < 76)
				act = dstk_pkg::ACT_ROT;
			else if (pick < 94)
				act = dstk_pkg::ACT_PEEK;
			else
				act = dstk_pkg::ACTION_W'($urandom_range(0, 7));
			sel = $urandom_range(0, 99);
			if (sel < 5)
				val = 32'h0;
			else if (sel < 10)
				val = 32'hFFFF_FFFF;
			else
				val = $urandom;
			sel = $urandom_range(0, 99);
			if (act != dstk_pkg::ACT_PEEK || stk_count == 0 || sel < 5) begin
				off = dstk_pkg::OFFSET_W'($urandom_range(0, 255));
			end else if (sel < 85) begin
				top_off = (stk_count > 8) ? 7 : stk_count - 1;
				off = dstk_pkg::OFFSET_W'($urandom_range(0, top_off));
			end else begin
				off = dstk_pkg::OFFSET_W'($urandom_range(0, stk_count - 1));
			end
			send_item(act, val, off);
			if (act < 3'd6) sent++;
		end
		wait_drained();
	endtask

	initial begin
		fail_count  = 0;
		cycle_count = 0;
		stk_count   = 0;
		hold_cycles = 0;
		send_idle   = 1'b1;
		recv_idle   = 1'b1;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		action      <= dstk_pkg::ACT_PUSH;
		push_value  <= '0;
		peek_offset <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_full_stack();
		test_output_stall();
		test_random();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dstk_pkg.sv
hw/rtl/dstk_cell.sv
hw/rtl/data_stack_with_dup_swap_rot.sv
dv/tb_data_stack_with_dup_swap_rot.sv
